>>> hw/rtl/mced_pkg.sv
// shared types, constants and register codes of the multi-channel edge debouncer
package mced_pkg;

    localparam int CHANNELS  = 8;
    localparam int TIME_BITS = 24;
    localparam int PIN_LANES = 8;
    // lanes actually built: never more than the pin field can carry
    localparam int LANES     = (CHANNELS < PIN_LANES) ? CHANNELS : PIN_LANES;

    localparam int CNT_BITS      = 4;
    localparam int INV_BITS      = 8;
    localparam int DEB_BITS      = 23;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_MASK    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_TICKS = 2'd2;

    localparam logic [CNT_BITS-1:0] CHANNEL_COUNT_RESET  = CNT_BITS'(8);
    localparam logic [INV_BITS-1:0] INVERT_MASK_RESET    = '0;
    // about 50 ms at a 16384 Hz tick
    localparam logic [DEB_BITS-1:0] DEBOUNCE_TICKS_RESET = DEB_BITS'(50 * 16384 / 1000);

    typedef logic [TIME_BITS-1:0] tick_time_t;
    typedef logic [DEB_BITS-1:0]  debounce_t;

    typedef struct packed {
        logic [7:0] pin_levels;
        logic [7:0] edge_events;
    } in_t;

    typedef struct packed {
        logic [7:0] rising_flags;
        logic [7:0] falling_flags;
        logic [7:0] stable_levels;
    } out_t;

    // per-tick control broadcast to every lane
    typedef struct packed {
        logic       advance;
        logic       first_tick;
        tick_time_t now;
        debounce_t  delay;
    } tick_ctl_t;

    // what one lane found on the current tick
    typedef struct packed {
        logic rise;
        logic fall;
        logic stable;
    } lane_res_t;

endpackage

>>> hw/rtl/multi_channel_edge_debouncer.sv
// top level of the multi-channel edge debouncer: tick counter, config and lanes
//
// Every input transfer is one timer tick carrying the raw pin levels and the
// edge flags of up to eight channels, and every tick yields exactly one result
// transfer with rising flags, falling flags and the debounced levels. The
// block takes one tick per clock cycle while s_ready is high and registers its
// result in an output register; a skid register behind it holds one further
// result while the output stalls, after which s_ready drops until the result
// side drains. The rate is set by the per-lane path: one deadline add and one
// equality compare against the tick counter, done for all lanes in parallel.
// Configuration is a plain write port: index 0 channel_count, 1 invert_mask, 2
// debounce_ticks; other indexes are ignored. The first tick after reset only
// captures the initial levels and reports no flags.
module multi_channel_edge_debouncer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mced_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mced_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mced_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mced_pkg::out_t                      m_data
);

    // configuration registers
    logic [mced_pkg::CNT_BITS-1:0] channel_count_reg;
    logic [mced_pkg::INV_BITS-1:0] invert_mask_reg;
    mced_pkg::debounce_t           debounce_ticks_reg;

    // tick state shared by all lanes
    mced_pkg::tick_time_t tick_counter_reg, tick_counter_next;
    logic                 levels_captured_reg;

    logic                  accept;
    logic                  room;
    mced_pkg::tick_ctl_t   ctl;
    mced_pkg::lane_res_t   lane_res [mced_pkg::LANES];

    assign s_ready = room;
    assign accept  = s_valid && room;

    assign tick_counter_next = mced_pkg::TIME_BITS'(tick_counter_reg + 1'b1);

    always_comb begin
        ctl.advance    = accept;
        ctl.first_tick = !levels_captured_reg;
        ctl.now        = tick_counter_reg;
        ctl.delay      = debounce_ticks_reg;
    end

    // register writes: the user must write only while the block is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg  <= mced_pkg::CHANNEL_COUNT_RESET;
            invert_mask_reg    <= mced_pkg::INVERT_MASK_RESET;
            debounce_ticks_reg <= mced_pkg::DEBOUNCE_TICKS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mced_pkg::CFG_CHANNEL_COUNT: begin
                    channel_count_reg <= cfg_wdata[mced_pkg::CNT_BITS-1:0];
                end
                mced_pkg::CFG_INVERT_MASK: begin
                    invert_mask_reg <= cfg_wdata[mced_pkg::INV_BITS-1:0];
                end
                mced_pkg::CFG_DEBOUNCE_TICKS: begin
                    debounce_ticks_reg <= cfg_wdata[mced_pkg::DEB_BITS-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // tick time counter, advances once per accepted tick and wraps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_counter_reg    <= '0;
            levels_captured_reg <= 1'b0;
        end else if (accept) begin
            tick_counter_reg    <= tick_counter_next;
            levels_captured_reg <= 1'b1;
        end
    end

    // one lane per channel; a lane past channel_count keeps its state and reads zero
    for (genvar i = 0; i < mced_pkg::LANES; i++) begin : g_lane
        mced_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .active     (channel_count_reg > mced_pkg::CNT_BITS'(i)),
            .pin_level  (s_data.pin_levels[i]),
            .edge_event (s_data.edge_events[i]),
            .invert     (invert_mask_reg[i]),
            .res        (lane_res[i])
        );
    end

    mced_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .res     (lane_res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef ASSERT_OFF
    // a channel cannot rise and fall on the same tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.rising_flags & m_data.falling_flags) == '0))
        else $error("rising and falling flags overlap");

    // a rising flag always comes with a high debounced level
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.rising_flags & ~m_data.stable_levels) == '0))
        else $error("rising flag without high stable level");

    // input stalls only when both output and skid registers are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

    // each accepted tick advances the counter by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && accept) |=>
            (tick_counter_reg == mced_pkg::TIME_BITS'($past(tick_counter_reg) + 1'b1)))
        else $error("tick counter did not advance");

    // after an accepted tick the output holds a valid result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && accept) |=> m_valid)
        else $error("accepted tick produced no result");
`endif

endmodule

>>> hw/rtl/mced_lane.sv
// one debounce lane: deadline, armed flag and debounced level of a channel
module mced_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mced_pkg::tick_ctl_t   ctl,
    input  logic                  active,
    input  logic                  pin_level,
    input  logic                  edge_event,
    input  logic                  invert,
    output mced_pkg::lane_res_t   res
);

    mced_pkg::tick_time_t deadline_reg, deadline_next, deadline_eff;
    logic                 armed_reg, armed_next, armed_eff;
    logic                 level_reg, level_next;
    logic                 level, fire;

    always_comb begin
        level        = pin_level ^ invert;
        // an edge re-arms first, so a stale deadline never fires on the same tick
        deadline_eff = edge_event ?
                       mced_pkg::TIME_BITS'(ctl.now + mced_pkg::TIME_BITS'(ctl.delay)) :
                       deadline_reg;
        armed_eff    = edge_event | armed_reg;
        fire         = !ctl.first_tick && armed_eff && (deadline_eff == ctl.now);

        if (ctl.first_tick) begin
            level_next    = level;
            deadline_next = deadline_reg;
            armed_next    = armed_reg;
        end else begin
            level_next    = fire ? level : level_reg;
            deadline_next = deadline_eff;
            armed_next    = armed_eff & ~fire;
        end

        res.rise   = active & fire & level & ~level_reg;
        res.fall   = active & fire & ~level & level_reg;
        res.stable = active & level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadline_reg <= '0;
            armed_reg    <= 1'b0;
            level_reg    <= 1'b0;
        end else if (ctl.advance && active) begin
            deadline_reg <= deadline_next;
            armed_reg    <= armed_next;
            level_reg    <= level_next;
        end
    end

endmodule

>>> hw/rtl/mced_merge.sv
// gathers lane results into one result and holds it in an output register with skid
module mced_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mced_pkg::lane_res_t res [mced_pkg::LANES],
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output mced_pkg::out_t      m_data
);

    mced_pkg::out_t merged;
    mced_pkg::out_t out_reg, out_next, skid_reg, skid_next;
    logic           out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic           pop;

    always_comb begin
        merged = '0;
        for (int i = 0; i < mced_pkg::LANES; i++) begin
            merged.rising_flags[i]  = res[i].rise;
            merged.falling_flags[i] = res[i].fall;
            merged.stable_levels[i] = res[i].stable;
        end
    end

    assign pop     = out_valid_reg && m_ready;
    assign room    = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            // no push possible while the skid holds a result
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = merged;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = merged;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the multi-channel edge debouncer: tick stream, predictor, checker
module tb_top;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int unsigned DELAY_MAX   = 23'h7fffff;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #2 aclk = ~aclk;

    // block ports, all at known values from time zero
    logic                               cfg_wr_en = 1'b0;
    logic [mced_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [mced_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    mced_pkg::in_t                      s_data    = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    mced_pkg::out_t                     m_data;

    multi_channel_edge_debouncer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ticks waiting to be driven and flag words still owed by the block
    mced_pkg::in_t  ticks_pending[$];
    mced_pkg::out_t flags_due[$];

    // idle rates in percent for both sides, changed between phases
    int send_idle_pct = 38;
    int recv_idle_pct = 48;

    int mismatches  = 0;
    int cycle_count = 0;

    // last pin levels handed to the block, so bounce bursts stay plausible
    logic [7:0] pin_now = '0;

    // predictor copy of the register file
    logic [mced_pkg::CNT_BITS-1:0] count_cfg  = mced_pkg::CHANNEL_COUNT_RESET;
    logic [mced_pkg::INV_BITS-1:0] invert_cfg = mced_pkg::INVERT_MASK_RESET;
    logic [mced_pkg::DEB_BITS-1:0] delay_cfg  = mced_pkg::DEBOUNCE_TICKS_RESET;

    // predictor copy of the channel state
    mced_pkg::tick_time_t tick_now             = '0;
    mced_pkg::tick_time_t deadline_at [8]      = '{default: '0};
    logic [7:0]           armed_mask           = '0;
    logic [7:0]           stable_mask          = '0;
    logic                 initial_levels_taken = 1'b0;

    // advance the predicted state by one tick and return the flag word it owes
    function automatic mced_pkg::out_t debounce_tick(mced_pkg::in_t t);
        mced_pkg::out_t r;
        logic [7:0]     lvl;
        int             active;
        r      = '0;
        lvl    = t.pin_levels ^ invert_cfg;
        // channel counts past the built lanes saturate
        active = (int'(count_cfg) > mced_pkg::LANES) ? mced_pkg::LANES : int'(count_cfg);
        for (int i = 0; i < active; i++) begin
            if (!initial_levels_taken) begin
                // first tick: capture the levels, edges ignored, no flags
                stable_mask[i] = lvl[i];
            end else begin
                // an edge re-arms first, so a deadline landing on this tick is replaced by the new one
                if (t.edge_events[i]) begin
                    deadline_at[i] = tick_now + mced_pkg::tick_time_t'(delay_cfg);
                    armed_mask[i]  = 1'b1;
                end
                if (armed_mask[i] && deadline_at[i] == tick_now) begin
                    if (lvl[i] && !stable_mask[i])
                        r.rising_flags[i] = 1'b1;
                    if (!lvl[i] && stable_mask[i])
                        r.falling_flags[i] = 1'b1;
                    armed_mask[i]  = 1'b0;
                    stable_mask[i] = lvl[i];
                end
            end
            r.stable_levels[i] = stable_mask[i];
        end
        initial_levels_taken = 1'b1;
        tick_now++;
        return r;
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %02h, got %02h", what, want, got);
        end
    endtask

    // config write, only issued while nothing is in flight; predictor follows at once
    task automatic write_reg(logic [mced_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= mced_pkg::CFG_DATA_BITS'(val);
        case (idx)
            mced_pkg::CFG_CHANNEL_COUNT:  count_cfg  = mced_pkg::CNT_BITS'(val);
            mced_pkg::CFG_INVERT_MASK:    invert_cfg = mced_pkg::INV_BITS'(val);
            mced_pkg::CFG_DEBOUNCE_TICKS: delay_cfg  = mced_pkg::DEB_BITS'(val);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_tick(logic [7:0] pins, logic [7:0] edges);
        mced_pkg::in_t t;
        t.pin_levels  = pins;
        t.edge_events = edges;
        ticks_pending.push_back(t);
        pin_now = pins;
    endtask

    // wait until every tick went in and every flag word came out, so the output register
    // and skid stage are surely empty
    task automatic wait_idle();
        while (ticks_pending.size() != 0 || s_valid || flags_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly bounce bursts that settle and stay quiet long enough for the deadline,
    // some cut short so the next burst re-arms early, the rest pure noise ticks
    task automatic queue_bounce_segment(int n_ticks, int delay);
        int         made;
        int         quiet;
        int         blen;
        logic [7:0] mask;
        logic [7:0] target;
        logic [7:0] pins;
        made = 0;
        while (made < n_ticks) begin
            if ($urandom_range(0, 9) < 8) begin
                mask   = 8'($urandom_range(1, 255));
                target = 8'($urandom);
                blen   = $urandom_range(1, 5);
                for (int k = 0; k < blen; k++) begin
                    pins = (pin_now & ~mask) | (8'($urandom) & mask);
                    queue_tick(pins, ((pins ^ pin_now) | 8'($urandom)) & mask);
                end
                queue_tick((pin_now & ~mask) | (target & mask), mask);
                quiet = (delay > 16) ? $urandom_range(1, 8) : delay + $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0)
                    quiet = $urandom_range(0, quiet);
                repeat (quiet) queue_tick(pin_now, 8'h00);
                made += blen + 1 + quiet;
            end else begin
                queue_tick(8'($urandom), 8'($urandom));
                made++;
            end
        end
    endtask

    // driver: one transfer per tick, valid held with its payload until taken
    always @(posedge aclk) begin : tick_driver
        logic          next_valid;
        mced_pkg::in_t next_data;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_data  = s_data;
            if (s_valid && s_ready) begin
                flags_due.push_back(debounce_tick(s_data));
                next_valid = 1'b0;
            end
            if (!next_valid && ticks_pending.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                next_valid = 1'b1;
                next_data  = ticks_pending.pop_front();
            end
            s_valid <= next_valid;
            s_data  <= next_data;
        end
    end

    // monitor: random back-pressure, every result transfer checked against the oldest due word
    always @(posedge aclk) begin : flag_monitor
        mced_pkg::out_t want;
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (flags_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing due: %06h", m_data);
            end else begin
                want = flags_due.pop_front();
                check_field("rising_flags", want.rising_flags, m_data.rising_flags);
                check_field("falling_flags", want.falling_flags, m_data.falling_flags);
                check_field("stable_levels", want.stable_levels, m_data.stable_levels);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int d;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero delay fires in the same tick; inverted lanes on the first capture
        write_reg(mced_pkg::CFG_CHANNEL_COUNT, 8);
        write_reg(mced_pkg::CFG_INVERT_MASK, 8'h3c);
        write_reg(mced_pkg::CFG_DEBOUNCE_TICKS, 0);
        queue_tick(8'ha5, 8'hff);   // first tick only captures, edges ignored
        queue_tick(8'hff, 8'hff);
        queue_tick(8'h00, 8'hff);
        queue_tick(8'h00, 8'h00);
        queue_tick(8'h55, 8'haa);
        wait_idle();

        // three lanes, short delay: re-arm on an armed lane, edge on the deadline tick
        write_reg(mced_pkg::CFG_CHANNEL_COUNT, 3);
        write_reg(mced_pkg::CFG_INVERT_MASK, 8'hff);
        write_reg(mced_pkg::CFG_DEBOUNCE_TICKS, 2);
        queue_tick(8'h07, 8'h01);
        queue_tick(8'h07, 8'h00);
        queue_tick(8'h07, 8'h01);
        queue_tick(8'h07, 8'h00);
        queue_tick(8'h07, 8'h00);
        queue_tick(8'hff, 8'hfe);   // upper lanes inactive
        queue_tick(8'h00, 8'hfe);
        queue_tick(8'h00, 8'h00);
        queue_tick(8'h00, 8'h00);
        wait_idle();

        // no lanes active: everything reads zero
        write_reg(mced_pkg::CFG_CHANNEL_COUNT, 0);
        queue_tick(8'hff, 8'hff);
        queue_tick(8'h00, 8'h00);
        wait_idle();

        // count past eight saturates, longest delay parks the deadlines far away
        write_reg(mced_pkg::CFG_CHANNEL_COUNT, 15);
        write_reg(mced_pkg::CFG_INVERT_MASK, 8'h00);
        write_reg(mced_pkg::CFG_DEBOUNCE_TICKS, DELAY_MAX);
        queue_tick(8'hff, 8'hff);
        queue_tick(8'h00, 8'hff);
        wait_idle();

        // pull the parked deadlines back in
        write_reg(mced_pkg::CFG_CHANNEL_COUNT, 8);
        write_reg(mced_pkg::CFG_DEBOUNCE_TICKS, 3);
        queue_tick(8'haa, 8'hff);
        repeat (3) queue_tick(8'haa, 8'h00);
        wait_idle();

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int seg = 0; seg < 9; seg++) begin
            send_idle_pct = (seg < 3) ? 38 : (seg < 6) ? 48 : 0;
            recv_idle_pct = (seg < 3) ? 48 : (seg < 6) ? 38 : 0;
            d = (seg == 1) ? 1 : $urandom_range(0, 12);
            write_reg(mced_pkg::CFG_CHANNEL_COUNT,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8);
            write_reg(mced_pkg::CFG_INVERT_MASK, $urandom_range(0, 255));
            write_reg(mced_pkg::CFG_DEBOUNCE_TICKS, d);
            if (seg == 4) begin
                // sender holds off mid-phase until the block has drained
                queue_bounce_segment(100, d);
                wait_idle();
                queue_bounce_segment(106, d);
            end else begin
                queue_bounce_segment(206, d);
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && flags_due.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mced_pkg.sv
hw/rtl/mced_lane.sv
hw/rtl/mced_merge.sv
hw/rtl/multi_channel_edge_debouncer.sv
tb/sv/tb_top.sv
